### rtl/core/tlbrf_pkg.sv
// ----------------------------------------------------------------------------
// tlbrf_pkg
// Shared types and constants of the TLB refill unit.
// ----------------------------------------------------------------------------
package tlbrf_pkg;

    localparam int NUM_FRAMES  = 32;
    localparam int TLB_ENTRIES = 4;
    localparam int PAGE_BYTES  = 128;
    localparam int FRAME_W     = $clog2(NUM_FRAMES);
    localparam int SLOT_W      = $clog2(TLB_ENTRIES);
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int VPN_W       = 25;
    localparam int NPAGES_W    = 26;

    localparam logic [1:0] ST_RESIDENT = 2'd0;
    localparam logic [1:0] ST_FAULT    = 2'd1;
    localparam logic [1:0] ST_ADDR_ERR = 2'd2;
    localparam logic [1:0] ST_DIRTY    = 2'd3;

    localparam logic ACT_REFILL = 1'b0;
    localparam logic ACT_DIRTY  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] vaddr;
        logic [7:0]  pid;
        logic [31:0] now;
        logic [1:0]  dirty_slot;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [4:0]       frame;
        logic [1:0]       slot;
        logic             page_out;
        logic [VPN_W-1:0] victim_vpn;
        logic [7:0]       victim_pid;
        logic             page_in;
    } rsp_t;

    // Controller to datapath.
    typedef struct packed {
        logic latch;     // capture request, clear scan state
        logic dirty_op;  // mark a TLB slot dirty and respond
        logic scan;      // examine frame at scan index
        logic evict;     // evict victim and install page
        logic insert;    // TLB insert of the target frame
        logic err;       // respond with an address error
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_last;
        logic hit;
        logic in_range;
    } sts_t;

endpackage

### rtl/core/tlbrf_ctrl.sv
// ----------------------------------------------------------------------------
// tlbrf_ctrl
// Sequencer of the TLB refill unit.
// ----------------------------------------------------------------------------
module tlbrf_ctrl
    import tlbrf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic action,
    input  sts_t sts,
    output logic busy,
    output cmd_t cmd
);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_EVICT, S_INSERT} state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    state_next = (action == ACT_DIRTY) ? S_IDLE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (sts.hit)
                    state_next = S_INSERT;
                else if (sts.in_range)
                    state_next = S_EVICT;
                else
                begin
                    cmd.err = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EVICT:
            begin
                cmd.evict = 1'b1;
                state_next = S_INSERT;
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        cmd.dirty_op = cmd.latch && (action == ACT_DIRTY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

### rtl/core/tlbrf_dp.sv
// ----------------------------------------------------------------------------
// tlbrf_dp
// Frame table, TLB and scan datapath of the TLB refill unit.
// ----------------------------------------------------------------------------
module tlbrf_dp
    import tlbrf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  req_t                req,
    input  logic [NPAGES_W-1:0] num_pages,
    input  cmd_t                cmd,
    output sts_t                sts,
    output logic                rsp_valid,
    output rsp_t                rsp
);

    localparam logic [SLOT_W:0] NO_SLOT = SLOT_W'(0) | (SLOT_W+1)'(TLB_ENTRIES);

    logic [TLB_ENTRIES-1:0] tlb_valid_reg;
    logic [TLB_ENTRIES-1:0] tlb_dirty_reg;
    logic [FRAME_W-1:0]     tlb_frame_reg [TLB_ENTRIES];
    logic [SLOT_W-1:0]      fifo_reg;

    logic [NUM_FRAMES-1:0]  fv_reg;
    logic [NUM_FRAMES-1:0]  fd_reg;
    logic [7:0]             fown_reg  [NUM_FRAMES];
    logic [VPN_W-1:0]       fpage_reg [NUM_FRAMES];
    logic [SLOT_W:0]        flink_reg [NUM_FRAMES];
    logic [31:0]            fuse_reg  [NUM_FRAMES];

    req_t                   rq_reg;
    logic [FRAME_W-1:0]     idx_reg;
    logic                   hit_reg;
    logic                   inv_reg;
    logic [FRAME_W-1:0]     inv_f_reg;
    logic [FRAME_W-1:0]     lru_f_reg;
    logic [31:0]            lru_t_reg;
    logic [FRAME_W-1:0]     tgt_reg;
    logic                   fault_reg;
    logic                   po_reg;
    logic [VPN_W-1:0]       vvpn_reg;
    logic [7:0]             vpid_reg;

    logic [31-PAGE_SHIFT:0] vpn_full;
    logic [VPN_W-1:0]       vpn;
    logic                   match;
    logic [FRAME_W-1:0]     vic;
    logic [SLOT_W-1:0]      ins_slot;
    logic                   any_free;

    // The page number of a 32-bit address always fits the page field.
    assign vpn_full = rq_reg.vaddr[31:PAGE_SHIFT];
    assign vpn      = vpn_full[VPN_W-1:0];
    assign match    = fv_reg[idx_reg] && (fown_reg[idx_reg] == rq_reg.pid)
                      && (fpage_reg[idx_reg] == vpn);
    assign vic      = inv_reg ? inv_f_reg : lru_f_reg;

    assign sts.scan_last = (idx_reg == FRAME_W'(NUM_FRAMES-1));
    assign sts.hit       = hit_reg;
    assign sts.in_range  = ({1'b0, vpn} < num_pages);

    always_comb
    begin
        ins_slot = fifo_reg;
        any_free = 1'b0;
        for (int s = TLB_ENTRIES-1; s >= 0; s--)
            if (!tlb_valid_reg[s])
            begin
                ins_slot = SLOT_W'(s);
                any_free = 1'b1;
            end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlb_valid_reg <= '0;
            tlb_dirty_reg <= '0;
            fifo_reg      <= '0;
            fv_reg        <= '0;
            fd_reg        <= '0;
            for (int f = 0; f < NUM_FRAMES; f++)
            begin
                flink_reg[f] <= NO_SLOT;
                fuse_reg[f]  <= '0;
            end
            rsp_valid <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            rsp_valid <= 1'b0;
            if (cmd.latch)
            begin
                rq_reg    <= req;
                idx_reg   <= '0;
                hit_reg   <= 1'b0;
                inv_reg   <= 1'b0;
                lru_f_reg <= '0;
                lru_t_reg <= fuse_reg[0];
                fault_reg <= 1'b0;
                po_reg    <= 1'b0;
                vvpn_reg  <= '0;
                vpid_reg  <= '0;
            end
            if (cmd.dirty_op)
            begin
                tlb_dirty_reg[req.dirty_slot[SLOT_W-1:0]] <= 1'b1;
                rsp_valid <= 1'b1;
                rsp <= '{status: ST_DIRTY, slot: req.dirty_slot, default: '0};
            end
            if (cmd.scan)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (match && !hit_reg)
                begin
                    hit_reg   <= 1'b1;
                    tgt_reg   <= idx_reg;
                end
                if (!fv_reg[idx_reg] && !inv_reg)
                begin
                    inv_reg   <= 1'b1;
                    inv_f_reg <= idx_reg;
                end
                if (fuse_reg[idx_reg] < lru_t_reg)
                begin
                    lru_t_reg <= fuse_reg[idx_reg];
                    lru_f_reg <= idx_reg;
                end
            end
            if (cmd.err)
            begin
                rsp_valid <= 1'b1;
                rsp <= '{status: ST_ADDR_ERR, default: '0};
            end
            if (cmd.evict)
            begin
                tgt_reg   <= vic;
                fault_reg <= 1'b1;
                if (fv_reg[vic])
                begin
                    vvpn_reg <= fpage_reg[vic];
                    vpid_reg <= fown_reg[vic];
                    if (!flink_reg[vic][SLOT_W])
                    begin
                        po_reg <= tlb_dirty_reg[flink_reg[vic][SLOT_W-1:0]];
                        tlb_valid_reg[flink_reg[vic][SLOT_W-1:0]] <= 1'b0;
                    end
                    else
                        po_reg <= fd_reg[vic];
                end
                fv_reg[vic]    <= 1'b1;
                fown_reg[vic]  <= rq_reg.pid;
                fpage_reg[vic] <= vpn;
                fd_reg[vic]    <= 1'b0;
                flink_reg[vic] <= NO_SLOT;
            end
            if (cmd.insert)
            begin
                if (!any_free)
                begin
                    fd_reg[tlb_frame_reg[ins_slot]]    <= tlb_dirty_reg[ins_slot];
                    flink_reg[tlb_frame_reg[ins_slot]] <= NO_SLOT;
                end
                tlb_frame_reg[ins_slot] <= tgt_reg;
                tlb_valid_reg[ins_slot] <= 1'b1;
                // A frame replaced in its own slot keeps the slot's dirty bit.
                if (!any_free && tlb_frame_reg[ins_slot] == tgt_reg)
                    tlb_dirty_reg[ins_slot] <= tlb_dirty_reg[ins_slot];
                else
                    tlb_dirty_reg[ins_slot] <= fd_reg[tgt_reg];
                if (!any_free && tlb_frame_reg[ins_slot] == tgt_reg)
                    fd_reg[tgt_reg] <= tlb_dirty_reg[ins_slot];
                flink_reg[tgt_reg] <= {1'b0, ins_slot};
                fuse_reg[tgt_reg]  <= rq_reg.now;
                fifo_reg  <= ins_slot + 1'b1;
                rsp_valid <= 1'b1;
                rsp <= '{status: fault_reg ? ST_FAULT : ST_RESIDENT,
                         frame: tgt_reg, slot: ins_slot, page_out: po_reg,
                         victim_vpn: vvpn_reg, victim_pid: vpid_reg,
                         page_in: fault_reg};
            end
        end
    end

endmodule

### rtl/core/tlb_refill_inverted_table_lru_unit.sv
// ----------------------------------------------------------------------------
// tlb_refill_inverted_table_lru_unit
// TLB miss handler and dirty marker over an inverted frame table with LRU replacement.
// ----------------------------------------------------------------------------
//  channel   signals                  handshake
//  request   start, busy, req         taken when start is high and busy low
//  result    rsp_valid, rsp           one-cycle strobe, cannot be stalled
//  config    cfg_valid, cfg_ready,    written when both are high
//            cfg_data
//
// A dirty request answers in the next cycle. A refill request scans the frame
// table one frame per cycle; on a hit it inserts the found frame, on a miss
// in range it first evicts a victim, else it answers with an address error.
// Reset clears all valid bits at once, with no clearing pass. Busy holds off
// new requests while one is in flight; results are never stalled.
module tlb_refill_inverted_table_lru_unit
    import tlbrf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  req_t                req,
    output logic                rsp_valid,
    output rsp_t                rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [NPAGES_W-1:0] cfg_data
);

    logic [NPAGES_W-1:0] num_pages_reg;
    cmd_t cmd;
    sts_t sts;

    // The register is always writable; writes are to be made only while idle, which the block does not enforce.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_pages_reg <= '0;
        else if (cfg_valid)
            num_pages_reg <= cfg_data;
    end

    tlbrf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (req.action),
        .sts    (sts),
        .busy   (busy),
        .cmd    (cmd)
    );

    tlbrf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .num_pages (num_pages_reg),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

### rtl/core/tlbrf_check.sv
// ----------------------------------------------------------------------------
// tlbrf_check
// Port-level checks of the TLB refill unit.
// ----------------------------------------------------------------------------
module tlbrf_check
    import tlbrf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input req_t req,
    input logic rsp_valid,
    input rsp_t rsp
);

    a_dirty_fast: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.action == ACT_DIRTY |=> rsp_valid && rsp.status == ST_DIRTY)
        else $error("dirty request not answered next cycle");

    a_refill_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.action == ACT_REFILL |=> busy && !rsp_valid)
        else $error("refill request did not occupy the unit");

    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_ADDR_ERR |-> rsp.frame == '0 && !rsp.page_in)
        else $error("address error carries data");

    a_pagein: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.page_in == (rsp.status == ST_FAULT)))
        else $error("page_in disagrees with status");

endmodule

bind tlb_refill_inverted_table_lru_unit tlbrf_check u_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .req(req), .rsp_valid(rsp_valid), .rsp(rsp)
);
